/* rtl/esc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_pkg
// Constants and month table for the epoch seconds to calendar converter.
// ----------------------------------------------------------------------------
package esc_pkg;

	localparam int unsigned SecsPerDay     = 86400;
	localparam int unsigned DaysRecip      = 49710;  // floor(2^25 / 675)
	localparam int unsigned DaysRecipShift = 25;
	localparam int unsigned DaysDiv        = 675;    // 86400 >> 7
	localparam int unsigned HourRecip      = 4661;   // ceil(2^20 / 225)
	localparam int unsigned HourRecipShift = 20;
	localparam int unsigned SecsPerHour    = 3600;
	localparam int unsigned WdayRecip      = 74899;  // ceil(2^19 / 7)
	localparam int unsigned WdayRecipShift = 19;
	localparam int unsigned CycleRecip     = 45934;  // ceil(2^26 / 1461)
	localparam int unsigned CycleRecipShift = 26;
	localparam int unsigned CycleDays      = 1461;
	localparam int unsigned MinRecip       = 1093;   // ceil(2^14 / 15)
	localparam int unsigned MinRecipShift  = 14;
	localparam int unsigned Mar2100        = 48272;  // 2100-03-01 counted from 1968-01-01
	localparam int unsigned Year2100       = 200;

	typedef logic [15:0] day_cnt_t;

	function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] m);
		logic [8:0] v;
		v = 9'd0;
		case (m)
			4'd1:  v = 9'd31;
			4'd2:  v = leap ? 9'd60  : 9'd59;
			4'd3:  v = leap ? 9'd91  : 9'd90;
			4'd4:  v = leap ? 9'd121 : 9'd120;
			4'd5:  v = leap ? 9'd152 : 9'd151;
			4'd6:  v = leap ? 9'd182 : 9'd181;
			4'd7:  v = leap ? 9'd213 : 9'd212;
			4'd8:  v = leap ? 9'd244 : 9'd243;
			4'd9:  v = leap ? 9'd274 : 9'd273;
			4'd10: v = leap ? 9'd305 : 9'd304;
			4'd11: v = leap ? 9'd335 : 9'd334;
			default: v = 9'd0;
		endcase
		return v;
	endfunction

endpackage

/* rtl/epoch_seconds_to_calendar_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_core
// Unsigned epoch seconds plus a signed zone offset to a Gregorian breakdown.
// ----------------------------------------------------------------------------
// channel  direction  handshake              payload
// input    in         in_valid / in_stall    epoch_seconds
// output   out        out_valid / out_stall  second .. leap_year
// config   in         cfg_valid / cfg_ready  utc_offset_seconds
//
// Seven register stages; one transaction per cycle while the output is not stalled.
// The stage count follows the chain of reciprocal multiplications and their corrections.
// All stages advance together; a stall while the output is valid freezes the whole pipe.
// Reset clears valid bits and the offset; no clearing pass.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_core
	import esc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic signed [17:0] utc_offset_seconds,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [31:0]       epoch_seconds,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [5:0]        second,
	output logic [5:0]        minute,
	output logic [4:0]        hour,
	output logic [2:0]        weekday,
	output logic [7:0]        year_since_1900,
	output logic [8:0]        day_of_year,
	output logic [3:0]        month,
	output logic [4:0]        day_of_month,
	output logic              leap_year
);

	logic signed [17:0] offset_q;
	logic               adv;
	logic [6:0]         v_q;

	logic [24:0] x_s1;
	logic [6:0]  lo_s1;
	logic [40:0] p_s1;

	logic [15:0] days_s2;
	logic [16:0] sod_s2;

	day_cnt_t    d_s3;
	logic [16:0] sod_s3;

	logic [16:0] sod_s4;
	logic [24:0] hp_s4;
	logic [15:0] wx_s4;
	logic [31:0] wp_s4;
	logic [15:0] e_s4;
	logic [31:0] ep_s4;

	logic [4:0]  hour_s5;
	logic [11:0] hrem_s5;
	logic [2:0]  wd_s5;
	logic [5:0]  c_s5;
	logic [10:0] r_s5;

	logic [4:0]  hour_s6;
	logic [11:0] hrem_s6;
	logic [2:0]  wd_s6;
	logic [19:0] mp_s6;
	logic [7:0]  year_s6;
	logic [8:0]  doy_s6;
	logic        leap_s6;

	// stage combinational values
	logic [15:0] qe_c;
	logic [24:0] r2_full_c;
	logic [10:0] r2_c;
	logic [15:0] days_c;
	logic [9:0]  r2f_c;
	logic signed [19:0] rem_c;
	logic signed [19:0] rem_adj_c;
	logic [15:0] d_c;
	logic [15:0] e_raw_c;
	logic [15:0] e_c;
	logic [4:0]  hour_c;
	logic [16:0] hrem_full_c;
	logic [12:0] wq_c;
	logic [15:0] wd_full_c;
	logic [5:0]  c_c;
	logic [15:0] r5_full_c;
	logic [1:0]  yi_c;
	logic [10:0] doyf_c;
	logic [7:0]  year_c;
	logic        is2100_c;
	logic [8:0]  doy_c;
	logic [5:0]  min_c;
	logic [11:0] sec_full_c;
	logic [3:0]  mon_c;
	logic [8:0]  cum_c;

	assign cfg_ready = 1'b1;
	assign adv       = !(v_q[6] && out_stall);
	assign in_stall  = !adv;
	assign out_valid = v_q[6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (cfg_valid) begin
			offset_q <= utc_offset_seconds;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[5:0], in_valid};
		end
	end

	always_comb begin
		qe_c      = p_s1[40:25];
		r2_full_c = x_s1 - 25'(qe_c * 16'(DaysDiv));
		r2_c      = r2_full_c[10:0];
		days_c    = qe_c;
		r2f_c     = r2_c[9:0];
		if (r2_c >= 11'(DaysDiv)) begin
			days_c = qe_c + 16'd1;
			r2f_c  = 10'(r2_c - 11'(DaysDiv));
		end

		rem_c     = $signed({3'b000, sod_s2}) + 20'(offset_q);
		rem_adj_c = rem_c;
		d_c       = days_s2 + 16'd365;
		if (rem_c < -20'sd86400) begin
			rem_adj_c = rem_c + 20'sd172800;
			d_c       = days_s2 + 16'd363;
		end else if (rem_c < 20'sd0) begin
			rem_adj_c = rem_c + 20'sd86400;
			d_c       = days_s2 + 16'd364;
		end else if (rem_c >= 20'sd172800) begin
			rem_adj_c = rem_c - 20'sd172800;
			d_c       = days_s2 + 16'd367;
		end else if (rem_c >= 20'sd86400) begin
			rem_adj_c = rem_c - 20'sd86400;
			d_c       = days_s2 + 16'd366;
		end

		e_raw_c = d_s3 + 16'd366;
		e_c     = (e_raw_c >= 16'(Mar2100)) ? e_raw_c + 16'd1 : e_raw_c;

		hour_c      = hp_s4[24:20];
		hrem_full_c = sod_s4 - 17'(hour_c * 12'(SecsPerHour));
		wq_c        = wp_s4[31:19];
		wd_full_c   = wx_s4 - 16'({wq_c, 3'b000} - {3'b000, wq_c});
		c_c         = ep_s4[31:26];
		r5_full_c   = e_s4 - 16'(c_c * 11'(CycleDays));

		if (r_s5 < 11'd366) begin
			yi_c = 2'd0; doyf_c = r_s5;
		end else if (r_s5 < 11'd731) begin
			yi_c = 2'd1; doyf_c = r_s5 - 11'd366;
		end else if (r_s5 < 11'd1096) begin
			yi_c = 2'd2; doyf_c = r_s5 - 11'd731;
		end else begin
			yi_c = 2'd3; doyf_c = r_s5 - 11'd1096;
		end
		year_c   = 8'd68 + {c_s5, 2'b00} + {6'd0, yi_c};
		is2100_c = (year_c == 8'(Year2100));
		doy_c    = (is2100_c && doyf_c >= 11'd60) ? 9'(doyf_c - 11'd1) : doyf_c[8:0];

		min_c      = mp_s6[19:14];
		sec_full_c = hrem_s6 - 12'(min_c * 6'd60);
		mon_c      = 4'd0;
		for (int k = 1; k < 12; k++) begin
			if (doy_s6 >= cum_days(leap_s6, 4'(k))) begin
				mon_c = 4'(k);
			end
		end
		cum_c = cum_days(leap_s6, mon_c);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1  <= epoch_seconds[31:7];
			lo_s1 <= epoch_seconds[6:0];
			p_s1  <= 41'(epoch_seconds[31:7] * 16'(DaysRecip));

			days_s2 <= days_c;
			sod_s2  <= {r2f_c, lo_s1};

			d_s3   <= d_c;
			sod_s3 <= rem_adj_c[16:0];

			sod_s4 <= sod_s3;
			hp_s4  <= 25'(sod_s3[16:4] * 13'(HourRecip));
			wx_s4  <= d_s3 + 16'd3;
			wp_s4  <= 32'((d_s3 + 16'd3) * 17'(WdayRecip));
			e_s4   <= e_c;
			ep_s4  <= 32'(e_c * 16'(CycleRecip));

			hour_s5 <= hour_c;
			hrem_s5 <= hrem_full_c[11:0];
			wd_s5   <= wd_full_c[2:0];
			c_s5    <= c_c;
			r_s5    <= r5_full_c[10:0];

			hour_s6 <= hour_s5;
			hrem_s6 <= hrem_s5;
			wd_s6   <= wd_s5;
			mp_s6   <= 20'(hrem_s5[11:2] * 11'(MinRecip));
			year_s6 <= year_c;
			doy_s6  <= doy_c;
			leap_s6 <= (yi_c == 2'd0) && !is2100_c;

			second          <= sec_full_c[5:0];
			minute          <= min_c;
			hour            <= hour_s6;
			weekday         <= wd_s6;
			year_since_1900 <= year_s6;
			day_of_year     <= doy_s6;
			month           <= mon_c;
			day_of_month    <= 5'(doy_s6 - cum_c + 9'd1);
			leap_year       <= leap_s6;
		end
	end

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hour < 5'd24 && minute < 6'd60 && second < 6'd60))
		else $error("time of day out of range");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (month < 4'd12 && day_of_month != 5'd0 && weekday < 3'd7))
		else $error("date out of range");

	a_year_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !leap_year |-> day_of_year < 9'd365)
		else $error("day of year beyond common year");

endmodule

/* verif/tb_epoch_seconds_to_calendar_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_calendar_core
// Self-checking bench for the epoch seconds to calendar converter. Drives
// directed and random timestamps under several zone offsets and under sender
// idling and receiver stalling phases, and compares every result field
// against a behavioural calendar computation kept in a small scoreboard.
// ----------------------------------------------------------------------------
typedef struct {
	logic [5:0] second;
	logic [5:0] minute;
	logic [4:0] hour;
	logic [2:0] weekday;
	logic [7:0] year_since_1900;
	logic [8:0] day_of_year;
	logic [3:0] month;
	logic [4:0] day_of_month;
	logic       leap_year;
} calendar_t;

class calendar_scoreboard;
	calendar_t pending[$];
	longint offset;
	int errors;

	function new();
		offset = 0;
		errors = 0;
	endfunction

	static function bit is_leap(longint y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	static function longint month_start(bit leap, int m);
		int common[13] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};
		return common[m] + ((leap && m >= 2) ? 1 : 0);
	endfunction

	function void note_timestamp(logic [31:0] secs);
		calendar_t c;
		longint days, rem, wd, d, y;
		bit leap;
		int m;
		days = secs / 86400;
		rem = (secs % 86400) + offset;
		while (rem < 0) begin
			rem += 86400;
			days--;
		end
		while (rem >= 86400) begin
			rem -= 86400;
			days++;
		end
		wd = (4 + days) % 7;
		if (wd < 0) wd += 7;
		d = days + 365;
		y = 1969;
		while (d >= (is_leap(y) ? 366 : 365)) begin
			d -= is_leap(y) ? 366 : 365;
			y++;
		end
		leap = is_leap(y);
		m = 11;
		while (m > 0 && d < month_start(leap, m)) m--;
		c.second = 6'(rem % 60);
		c.minute = 6'((rem % 3600) / 60);
		c.hour = 5'(rem / 3600);
		c.weekday = 3'(wd);
		c.year_since_1900 = 8'(y - 1900);
		c.day_of_year = 9'(d);
		c.month = 4'(m);
		c.day_of_month = 5'(d - month_start(leap, m) + 1);
		c.leap_year = leap;
		pending.push_back(c);
	endfunction

	function void check_result(calendar_t got);
		calendar_t e;
		if (pending.size() == 0) begin
			$error("unexpected result transaction");
			errors++;
			return;
		end
		e = pending.pop_front();
		if (got.second !== e.second) begin
			$error("second: expected %0d actual %0d", e.second, got.second); errors++;
		end
		if (got.minute !== e.minute) begin
			$error("minute: expected %0d actual %0d", e.minute, got.minute); errors++;
		end
		if (got.hour !== e.hour) begin
			$error("hour: expected %0d actual %0d", e.hour, got.hour); errors++;
		end
		if (got.weekday !== e.weekday) begin
			$error("weekday: expected %0d actual %0d", e.weekday, got.weekday); errors++;
		end
		if (got.year_since_1900 !== e.year_since_1900) begin
			$error("year_since_1900: expected %0d actual %0d", e.year_since_1900,
				got.year_since_1900); errors++;
		end
		if (got.day_of_year !== e.day_of_year) begin
			$error("day_of_year: expected %0d actual %0d", e.day_of_year, got.day_of_year);
			errors++;
		end
		if (got.month !== e.month) begin
			$error("month: expected %0d actual %0d", e.month, got.month); errors++;
		end
		if (got.day_of_month !== e.day_of_month) begin
			$error("day_of_month: expected %0d actual %0d", e.day_of_month,
				got.day_of_month); errors++;
		end
		if (got.leap_year !== e.leap_year) begin
			$error("leap_year: expected %0d actual %0d", e.leap_year, got.leap_year); errors++;
		end
	endfunction
endclass

module tb_epoch_seconds_to_calendar_core;
	import esc_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic signed [17:0] utc_offset_seconds = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [31:0] epoch_seconds = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [5:0] second, minute;
	logic [4:0] hour;
	logic [2:0] weekday;
	logic [7:0] year_since_1900;
	logic [8:0] day_of_year;
	logic [3:0] month;
	logic [4:0] day_of_month;
	logic leap_year;

	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	calendar_scoreboard sb = new();

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	epoch_seconds_to_calendar_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .utc_offset_seconds(utc_offset_seconds),
		.in_valid(in_valid), .in_stall(in_stall), .epoch_seconds(epoch_seconds),
		.out_valid(out_valid), .out_stall(out_stall),
		.second(second), .minute(minute), .hour(hour), .weekday(weekday),
		.year_since_1900(year_since_1900), .day_of_year(day_of_year), .month(month),
		.day_of_month(day_of_month), .leap_year(leap_year)
	);

	always @(posedge clk) begin
		calendar_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.second = second;
			got.minute = minute;
			got.hour = hour;
			got.weekday = weekday;
			got.year_since_1900 = year_since_1900;
			got.day_of_year = day_of_year;
			got.month = month;
			got.day_of_month = day_of_month;
			got.leap_year = leap_year;
			sb.check_result(got);
		end
		out_stall <= ($urandom_range(99) < receiver_stall_pct);
	end

	task automatic send_timestamp(logic [31:0] secs);
		while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		epoch_seconds <= secs;
		do @(posedge clk); while (in_stall);
		sb.note_timestamp(secs);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_offset(logic signed [17:0] v);
		drain();
		cfg_valid <= 1'b1;
		utc_offset_seconds <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.offset = longint'(v);
	endtask

	function automatic logic [31:0] random_timestamp();
		case ($urandom_range(3))
			0: return $urandom();
			1: return $urandom_range(200000);
			2: return 32'hFFFF_FFFF - $urandom_range(200000);
			default: return 32'(($urandom_range(49710) * 86400) + $urandom_range(1) * 86399
				- $urandom_range(2) + 1);
		endcase
	endfunction

	function automatic logic signed [17:0] random_offset();
		case ($urandom_range(3))
			0: return -18'sd86399;
			1: return 18'sd86399;
			2: return 18'($urandom());
			default: return 18'sd0;
		endcase
	endfunction

	initial begin
		logic [31:0] directed[$] = '{32'd0, 32'd1, 32'd86399, 32'd86400, 32'd68169600,
			32'd68256000, 32'd951782400, 32'd951868799, 32'd978307199, 32'd1234567890,
			32'd4102444799, 32'd4107542400, 32'd4294967295, 32'h8000_0000, 32'h5555_5555,
			32'hAAAA_AAAA};
		logic signed [17:0] offsets[$] = '{18'sd0, -18'sd86399, 18'sd86399,
			18'sh1FFFF, -18'sh20000, 18'sd3600};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (offsets[i]) begin
			write_offset(offsets[i]);
			foreach (directed[j]) send_timestamp(directed[j]);
		end
		for (int ph = 0; ph < 4; ph++) begin
			sender_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 30 : 67) : 0;
			receiver_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 30 : 67) : 0;
			for (int k = 0; k < 4; k++) begin
				write_offset(random_offset());
				for (int n = 0; n < 50; n++) send_timestamp(random_timestamp());
			end
		end
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		drain();
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
